FILE: rtl/core/sha1_message_digest_macros.svh
// assertion macros for the sha1 message digest core
// expects clk and arst_n in the scope of use
`ifndef SHA1_MESSAGE_DIGEST_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_MACROS_SVH

// same-cycle implication, disabled in reset
`define SHA1_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define SHA1_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/sha1_pkg.sv
// types, constants and helpers for the sha1 message digest core
// no dependencies
package sha1_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} sha1_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} sha1_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} sha1_state_t;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	// initial chaining value, index 0 is the first word
	localparam logic [4:0][31:0] H_INIT = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [6:0] SCHED_START = 7'd16;
	localparam logic [6:0] PHASE1     = 7'd20;
	localparam logic [6:0] PHASE2     = 7'd40;
	localparam logic [6:0] PHASE3     = 7'd60;
	localparam logic [3:0] LEN_HI_WORD = 4'd14;
	localparam logic [3:0] LEN_LO_WORD = 4'd15;
	localparam logic [2:0] LAST_INDEX = 3'd4;

	// place a byte big-endian at lane, clearing the lanes after it
	function automatic logic [31:0] put_byte(logic [31:0] acc, logic [7:0] b, logic [1:0] lane);
		logic [31:0] w;
		unique case (lane)
			2'd0: w = {b, 24'h0};
			2'd1: w = {acc[31:24], b, 16'h0};
			2'd2: w = {acc[31:16], b, 8'h0};
			2'd3: w = {acc[31:8], b};
			default: w = {acc[31:8], b};
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/core/sha1_message_digest.sv
// sha1 message digest core: byte stream in, five digest words out
// depends on sha1_pkg and sha1_message_digest_macros.svh
//
// channel | signals                      | carries
// --------+------------------------------+------------------------------------------
// in      | in_valid, in_ready, in_data  | one request: optional byte, end mark
// out     | out_valid, out_ready, out_data | one digest word with index and last flag
//
// a byte that does not complete a 64-byte block is packed into the partial word in ST_IDLE
// a byte that completes a block starts a compression: its accept, the rounds, then the add
// an end request adds the padding words and a compression per padded block (rounds, then add),
//   two blocks when fewer than 9 bytes are left, then five output requests
// in_ready is low during compression and from the start of padding until the last digest word
// leaves; out_ready low simply holds the current word; reset clears the message and loads H0
`include "sha1_message_digest_macros.svh"

module sha1_message_digest (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sha1_pkg::sha1_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output sha1_pkg::sha1_out_t out_data
);

	// sequencer state
	sha1_pkg::sha1_state_t state_q, state_next;

	// message bookkeeping
	logic [60:0] len_q;        // bytes so far, wraps mod 2^61
	logic [31:0] acc_q;        // partial word being packed
	logic [3:0]  wcnt_q;       // words shifted into the block so far
	logic        pend_end_q;   // end seen, finish after the current block
	logic        mark_done_q;  // 0x80 already placed
	logic        need_extra_q; // length goes into a further block
	logic        final_q;      // current block carries the length

	// message schedule as a 16-word shift line, word 0 is the oldest
	logic [31:0] w_q [16];

	// working variables and chaining value
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] chain_q [5];
	logic [6:0]  rnd_q;
	logic [2:0]  out_idx_q;

	// handshake strobes
	logic in_fire, out_fire;

	// control from the output decoder
	logic        shift_en;
	logic [31:0] shift_word;
	logic        launch;

	// round unit
	logic [31:0] w_cur, f_val, k_val, t_val;

	// packed words
	logic [31:0] byte_word, pad_word;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	assign byte_word = sha1_pkg::put_byte(acc_q, in_data.data_byte, len_q[1:0]);

	// padding stream: marker word, zeros, then the 64-bit bit length
	always_comb begin
		if (!mark_done_q) begin
			pad_word = sha1_pkg::put_byte(acc_q, sha1_pkg::PAD_BYTE, len_q[1:0]);
		end else if (need_extra_q) begin
			pad_word = '0;
		end else if (wcnt_q == sha1_pkg::LEN_HI_WORD) begin
			pad_word = len_q[60:29];
		end else if (wcnt_q == sha1_pkg::LEN_LO_WORD) begin
			pad_word = {len_q[28:0], 3'b000};
		end else begin
			pad_word = '0;
		end
	end

	// round unit: one sha-1 round per cycle
	always_comb begin
		if (rnd_q < sha1_pkg::SCHED_START) begin
			w_cur = w_q[0];
		end else begin
			w_cur = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
			w_cur = {w_cur[30:0], w_cur[31]};
		end
		priority if (rnd_q < sha1_pkg::PHASE1) begin
			f_val = (b_q & c_q) ^ (~b_q & d_q);
			k_val = sha1_pkg::K0;
		end else if (rnd_q < sha1_pkg::PHASE2) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = sha1_pkg::K1;
		end else if (rnd_q < sha1_pkg::PHASE3) begin
			f_val = (b_q & c_q) ^ (b_q & d_q) ^ (c_q & d_q);
			k_val = sha1_pkg::K2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = sha1_pkg::K3;
		end
		t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w_cur;
	end

	// output decoder of the sequencer
	always_comb begin
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		shift_en   = 1'b0;
		shift_word = '0;
		unique case (state_q)
			sha1_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire && in_data.byte_valid && (len_q[1:0] == 2'd3)) begin
					shift_en   = 1'b1;
					shift_word = byte_word;
				end
			end
			sha1_pkg::ST_PAD: begin
				shift_en   = 1'b1;
				shift_word = pad_word;
			end
			sha1_pkg::ST_ROUND: begin
				shift_en   = 1'b1;
				shift_word = w_cur;
			end
			sha1_pkg::ST_ADD: begin
			end
			sha1_pkg::ST_OUT: begin
				out_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sixteenth word entering the line starts a compression
	assign launch = shift_en && (state_q != sha1_pkg::ST_ROUND) && (wcnt_q == 4'd15);

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			sha1_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (launch) begin
						state_next = sha1_pkg::ST_ROUND;
					end else if (in_data.end_of_message) begin
						state_next = sha1_pkg::ST_PAD;
					end
				end
			end
			sha1_pkg::ST_PAD: begin
				if (launch) begin
					state_next = sha1_pkg::ST_ROUND;
				end
			end
			sha1_pkg::ST_ROUND: begin
				if (rnd_q == sha1_pkg::LAST_ROUND) begin
					state_next = sha1_pkg::ST_ADD;
				end
			end
			sha1_pkg::ST_ADD: begin
				priority if (final_q) begin
					state_next = sha1_pkg::ST_OUT;
				end else if (pend_end_q) begin
					state_next = sha1_pkg::ST_PAD;
				end else begin
					state_next = sha1_pkg::ST_IDLE;
				end
			end
			sha1_pkg::ST_OUT: begin
				if (out_fire && (out_idx_q == sha1_pkg::LAST_INDEX)) begin
					state_next = sha1_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = sha1_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sha1_pkg::ST_IDLE;
			len_q        <= '0;
			wcnt_q       <= '0;
			pend_end_q   <= 1'b0;
			mark_done_q  <= 1'b0;
			need_extra_q <= 1'b0;
			final_q      <= 1'b0;
			rnd_q        <= '0;
			out_idx_q    <= '0;
		end else begin
			state_q <= state_next;
			if (shift_en && (state_q != sha1_pkg::ST_ROUND)) begin
				wcnt_q <= wcnt_q + 4'd1;
			end
			if (in_fire) begin
				if (in_data.byte_valid) begin
					len_q <= len_q + 61'd1;
				end
				pend_end_q <= in_data.end_of_message;
			end
			if (state_q == sha1_pkg::ST_PAD) begin
				if (!mark_done_q) begin
					mark_done_q <= 1'b1;
					// marker in word 14 leaves no room for the length
					need_extra_q <= (wcnt_q == sha1_pkg::LEN_HI_WORD);
				end else if (need_extra_q) begin
					if (launch) begin
						need_extra_q <= 1'b0;
					end
				end else if (launch) begin
					final_q <= 1'b1;
				end
			end
			if (launch) begin
				rnd_q <= '0;
			end else if (state_q == sha1_pkg::ST_ROUND) begin
				rnd_q <= rnd_q + 7'd1;
			end
			if (out_fire) begin
				if (out_idx_q == sha1_pkg::LAST_INDEX) begin
					// digest delivered: back to an empty message
					out_idx_q   <= '0;
					len_q       <= '0;
					wcnt_q      <= '0;
					pend_end_q  <= 1'b0;
					mark_done_q <= 1'b0;
					final_q     <= 1'b0;
				end else begin
					out_idx_q <= out_idx_q + 3'd1;
				end
			end
		end
	end

	// chaining value: feed-forward add, rotates out during delivery
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) begin
				chain_q[i] <= sha1_pkg::H_INIT[i];
			end
		end else begin
			if (state_q == sha1_pkg::ST_ADD) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end else if (out_fire) begin
				if (out_idx_q == sha1_pkg::LAST_INDEX) begin
					for (int i = 0; i < 5; i++) begin
						chain_q[i] <= sha1_pkg::H_INIT[i];
					end
				end else begin
					for (int i = 0; i < 4; i++) begin
						chain_q[i] <= chain_q[i + 1];
					end
					chain_q[4] <= chain_q[0];
				end
			end
		end
	end

	// payload registers: partial word, schedule line, working variables
	always_ff @(posedge clk) begin
		if (in_fire && in_data.byte_valid) begin
			acc_q <= byte_word;
		end
		if (shift_en) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= shift_word;
		end
		if (launch) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (state_q == sha1_pkg::ST_ROUND) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	assign out_data.digest_word = chain_q[0];
	assign out_data.word_index  = out_idx_q;
	assign out_data.last_word   = (out_idx_q == sha1_pkg::LAST_INDEX);

	// checks
	`SHA1_ASSERT_SAME(a_busy_excl, in_ready, !out_valid, "input taken while digest pending")
	`SHA1_ASSERT_NEXT(a_back_idle, out_fire && out_data.last_word, in_ready,
		"not ready after last digest word")
	`SHA1_ASSERT_SAME(a_round_wcnt, state_q == sha1_pkg::ST_ROUND, wcnt_q == 4'd0,
		"block word count not cleared during rounds")
	`SHA1_ASSERT_SAME(a_round_cnt, state_q == sha1_pkg::ST_ROUND,
		rnd_q <= sha1_pkg::LAST_ROUND, "round counter overran")

endmodule
